@@ hw/rtl/spd_pkg.sv @@
// Shared types and constants for the serial packet deframer.
// No dependencies; imported by spd_frame_check and serial_packet_deframer_top.
`timescale 1ns / 1ps

package spd_pkg;

  // Packet geometry and checks
  localparam int unsigned PACKET_BYTES = 11;
  localparam int unsigned CNT_W        = $clog2(PACKET_BYTES + 1);
  localparam logic [7:0]  MAGIC_RESET  = 8'd67;
  localparam logic [7:0]  TYPE_LIMIT   = 8'd4;

  // Byte positions inside the window, oldest byte first
  localparam int unsigned POS_MAGIC = 0;
  localparam int unsigned POS_SUM   = 1;
  localparam int unsigned POS_TYPE  = 2;
  localparam int unsigned POS_ADDR  = 3;
  localparam int unsigned POS_DATA  = 7;

  typedef logic [PACKET_BYTES-1:0][7:0] spd_window_t;

  // One decoded packet together with its hit flag
  typedef struct packed {
    logic        hit;
    logic [1:0]  packet_type;
    logic [31:0] word_address;
    logic [31:0] data_word;
  } spd_result_t;

endpackage

@@ hw/rtl/serial_packet_deframer_top.sv @@
// Top level of the serial packet deframer: byte window, fill count, output stage.
// Depends on spd_pkg and spd_frame_check.
`timescale 1ns / 1ps

// The deframer takes one received byte per cycle while in_stall is low and keeps
// the last eleven bytes in a shift window. When the window holds eleven bytes
// starting with the magic byte, carrying a correct additive checksum in byte one
// and a type below four in byte two, one packet is delivered and the window
// empties; otherwise the window slides a byte at a time until it locks on. The
// window check is a small adder tree between the window registers and the output
// register; once a packet's last byte is transferred, it is registered into the
// output register, or into the skid entry while the output is stalled. The result
// side has an output register and one skid entry, so bytes keep flowing while a
// packet waits; in_stall rises only while the skid entry is occupied. The magic
// byte register resets to 'C' and may be rewritten whenever the block is idle.
module serial_packet_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_packet_type,
  output logic [31:0] out_word_address,
  output logic [31:0] out_data_word
);
  import spd_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(PACKET_BYTES);

  logic [7:0]       magic_r;
  spd_window_t      window_r;
  spd_window_t      window_nxt;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic             in_xfer;
  logic             will_fill;
  spd_result_t      check;
  logic             out_valid_r;
  spd_result_t      out_r;
  logic             skid_valid_r;
  spd_result_t      skid_r;
  logic             out_free;
  logic             new_hit;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = skid_valid_r;
  assign will_fill = (fill_r >= FULL_CNT - CNT_W'(1));

  // Window after appending the incoming byte, newest byte at the top.
  always_comb begin
    window_nxt = {in_rx_byte, window_r[PACKET_BYTES-1:1]};
  end

  spd_frame_check u_check (
    .window      (window_nxt),
    .magic_byte  (magic_r),
    .window_full (will_fill),
    .result      (check)
  );

  assign new_hit = in_xfer && check.hit;

  // Fill count saturates at a full window and clears on a packet.
  always_comb begin
    fill_nxt = fill_r;
    if (in_xfer) begin
      if (check.hit) begin
        fill_nxt = '0;
      end else if (!will_fill) begin
        fill_nxt = fill_r + CNT_W'(1);
      end else begin
        fill_nxt = FULL_CNT;
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MAGIC_RESET;
    end else if (cfg_wr_en) begin
      magic_r <= cfg_wr_data;
    end
  end

  // Window and fill count. Stale bytes below the fill mark are never checked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      window_r <= window_nxt;
    end
  end

  // Output register with one skid entry behind it.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= new_hit;
      end
    end else if (new_hit) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (new_hit) begin
        out_r <= check;
      end
    end else if (new_hit) begin
      skid_r <= check;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_packet_type  = out_r.packet_type;
  assign out_word_address = out_r.word_address;
  assign out_data_word    = out_r.data_word;

endmodule

@@ hw/rtl/spd_frame_check.sv @@
// Combinational packet check over a full 11-byte window.
// Depends on spd_pkg for the window and result types.
`timescale 1ns / 1ps

module spd_frame_check (
  input  spd_pkg::spd_window_t window,
  input  logic [7:0]           magic_byte,
  input  logic                 window_full,
  output spd_pkg::spd_result_t result
);
  import spd_pkg::*;

  logic [7:0] sum_a;
  logic [7:0] sum_b;
  logic [7:0] sum_c;
  logic [7:0] checksum;
  logic       magic_ok;
  logic       sum_ok;
  logic       type_ok;

  // Mod-256 sum of every byte but the checksum byte, as a shallow adder tree.
  assign sum_a    = (window[0] + window[2]) + (window[3] + window[4]);
  assign sum_b    = (window[5] + window[6]) + (window[7] + window[8]);
  assign sum_c    = window[9] + window[10];
  assign checksum = sum_a + sum_b + sum_c;

  // The three packet checks.
  assign magic_ok = (window[POS_MAGIC] == magic_byte);
  assign sum_ok   = (window[POS_SUM] == checksum);
  assign type_ok  = (window[POS_TYPE] < TYPE_LIMIT);

  // Little-endian field extraction.
  always_comb begin
    result.hit          = window_full && magic_ok && sum_ok && type_ok;
    result.packet_type  = window[POS_TYPE][1:0];
    result.word_address = {window[POS_ADDR+3], window[POS_ADDR+2],
                           window[POS_ADDR+1], window[POS_ADDR]};
    result.data_word    = {window[POS_DATA+3], window[POS_DATA+2],
                           window[POS_DATA+1], window[POS_DATA]};
  end

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for serial_packet_deframer_top: directed frames, then random
// byte streams under several magic byte settings and flow-control patterns.
// Depends on spd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb_top;
  import spd_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned PRINT_LIMIT    = 100;

  // One decoded packet as the deframer should deliver it
  typedef struct packed {
    logic [1:0]  ptype;
    logic [31:0] addr;
    logic [31:0] data;
  } packet_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_packet_type;
  logic [31:0] out_word_address;
  logic [31:0] out_data_word;

  // Shadow of the deframer state
  logic [7:0]  rx_window [PACKET_BYTES];
  int unsigned rx_fill;
  logic [7:0]  frame_magic;
  packet_t     pending_packets[$];

  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned bytes_sent;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  serial_packet_deframer_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_packet_type  (out_packet_type),
    .out_word_address (out_word_address),
    .out_data_word    (out_data_word)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // The receiver holds off result transfers at random according to the current phase.
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99, 0) < recv_stall_pct);
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT)
      $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Shifts one received byte into the shadow window and queues a packet when the
  // full window passes the magic, checksum and type checks.
  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0] sum;
    packet_t    pkt;
    if (rx_fill < PACKET_BYTES) begin
      rx_window[rx_fill] = b;
      rx_fill++;
    end else begin
      for (int i = 0; i < PACKET_BYTES - 1; i++)
        rx_window[i] = rx_window[i + 1];
      rx_window[PACKET_BYTES - 1] = b;
    end
    if (rx_fill == PACKET_BYTES) begin
      sum = 8'd0;
      for (int i = 0; i < PACKET_BYTES; i++)
        if (i != POS_SUM) sum += rx_window[i];
      if (rx_window[POS_MAGIC] == frame_magic && rx_window[POS_SUM] == sum &&
          rx_window[POS_TYPE] < TYPE_LIMIT) begin
        pkt.ptype = rx_window[POS_TYPE][1:0];
        pkt.addr  = {rx_window[POS_ADDR + 3], rx_window[POS_ADDR + 2],
                     rx_window[POS_ADDR + 1], rx_window[POS_ADDR]};
        pkt.data  = {rx_window[POS_DATA + 3], rx_window[POS_DATA + 2],
                     rx_window[POS_DATA + 1], rx_window[POS_DATA]};
        pending_packets.push_back(pkt);
        foreach (rx_window[i]) rx_window[i] = 8'd0;
        rx_fill = 0;
      end
    end
  endfunction

  // Compares one delivered packet with the oldest expected one.
  task automatic check_packet();
    packet_t want;
    if (pending_packets.size() == 0) begin
      report_mismatch($sformatf("unexpected packet type %0d addr %h data %h",
                                out_packet_type, out_word_address, out_data_word));
      return;
    end
    want = pending_packets.pop_front();
    if (out_packet_type !== want.ptype)
      report_mismatch($sformatf("packet_type %0d, expected %0d", out_packet_type, want.ptype));
    if (out_word_address !== want.addr)
      report_mismatch($sformatf("word_address %h, expected %h", out_word_address, want.addr));
    if (out_data_word !== want.data)
      report_mismatch($sformatf("data_word %h, expected %h", out_data_word, want.data));
  endtask

  // Observes every transfer on both channels and the register port, and
  // ends the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_packet();
      if (cfg_wr_en) frame_magic = cfg_wr_data;
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_wr_en)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles at %0t", quiet_cycles, $time);
        $display("serial_packet_deframer_top verification failed");
        $finish;
      end
    end
  end

  // Offers one byte, with random gaps in front, and returns at the edge of its transfer.
  task automatic send_byte(input logic [7:0] b);
    while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input spd_window_t frame, input int unsigned count);
    for (int i = 0; i < count; i++)
      send_byte(frame[i]);
  endtask

  // Builds a frame with a correct checksum for the given magic, type and fields.
  function automatic spd_window_t make_frame(input logic [7:0] magic, input logic [7:0] kind,
                                             input logic [31:0] addr, input logic [31:0] data);
    spd_window_t frame;
    logic [7:0]  sum;
    frame = '0;
    frame[POS_MAGIC] = magic;
    frame[POS_TYPE]  = kind;
    for (int k = 0; k < 4; k++) begin
      frame[POS_ADDR + k] = addr[8*k +: 8];
      frame[POS_DATA + k] = data[8*k +: 8];
    end
    sum = 8'd0;
    for (int i = 0; i < PACKET_BYTES; i++)
      if (i != POS_SUM) sum += frame[i];
    frame[POS_SUM] = sum;
    return frame;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9, 0))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Line noise, with a fair share of stray magic bytes to provoke false starts.
  function automatic logic [7:0] noise_byte();
    if ($urandom_range(3, 0) == 0) return frame_magic;
    return 8'($urandom_range(255, 0));
  endfunction

  // Stops offering bytes and waits until every expected packet has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_packets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_magic(input logic [7:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed frames with random content, mixed with rejected types, bad
  // checksums, bad magic bytes, truncated frames and bursts of noise.
  task automatic run_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    spd_window_t frame;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99, 0);
      if (pick < 30)
        repeat ($urandom_range(3, 1)) send_byte(noise_byte());
      frame = make_frame(frame_magic, 8'($urandom_range(3, 0)), pick_word(), pick_word());
      if (pick < 70) begin
        send_frame(frame, PACKET_BYTES);
      end else if (pick < 78) begin
        frame = make_frame(frame_magic, 8'($urandom_range(255, 32'(TYPE_LIMIT))),
                           pick_word(), pick_word());
        send_frame(frame, PACKET_BYTES);
      end else if (pick < 86) begin
        frame[POS_SUM] ^= 8'($urandom_range(255, 1));
        send_frame(frame, PACKET_BYTES);
      end else if (pick < 90) begin
        frame[POS_MAGIC] ^= 8'($urandom_range(255, 1));
        send_frame(frame, PACKET_BYTES);
      end else if (pick < 95) begin
        send_frame(frame, $urandom_range(PACKET_BYTES - 1, 1));
      end else begin
        repeat ($urandom_range(6, 1)) send_byte(noise_byte());
      end
    end
  endtask

  // Reset magic: a type zero frame with extreme fields, then a stray byte that forces
  // the window to slide before a type three frame locks on.
  task automatic test_reset_magic_frames();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_frame(make_frame(MAGIC_RESET, 8'd0, 32'hFFFF_FFFF, 32'h0000_0000), PACKET_BYTES);
    send_byte(8'hFF);
    send_frame(make_frame(MAGIC_RESET, 8'd3, 32'h0000_0000, 32'hFFFF_FFFF), PACKET_BYTES);
  endtask

  // Extreme magic values: zero with no idling, all ones with a slow sender.
  task automatic test_magic_extremes();
    write_magic(8'h00);
    run_traffic(400);
    write_magic(8'hFF);
    send_gap_pct = 72;
    run_traffic(400);
  endtask

  // A random magic byte while the receiver stalls most of the time.
  task automatic test_result_backpressure();
    write_magic(8'($urandom_range(255, 0)));
    send_gap_pct   = 0;
    recv_stall_pct = 72;
    run_traffic(400);
  endtask

  // Back to the reset magic with both sides idling now and then.
  task automatic test_mixed_idling();
    write_magic(MAGIC_RESET);
    send_gap_pct   = 25;
    recv_stall_pct = 25;
    run_traffic(430);
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= 8'd0;
    in_valid       <= 1'b0;
    in_rx_byte     <= 8'd0;
    out_stall      <= 1'b0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    bytes_sent     = 0;
    rx_fill        = 0;
    frame_magic    = MAGIC_RESET;
    foreach (rx_window[i]) rx_window[i] = 8'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_magic_frames();
    test_magic_extremes();
    test_result_backpressure();
    test_mixed_idling();

    // Let any late packet show up before the verdict.
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_packets.size() != 0)
      report_mismatch($sformatf("%0d expected packets never delivered", pending_packets.size()));
    if (mismatch_count == 0)
      $display("serial_packet_deframer_top verification clean");
    else
      $display("serial_packet_deframer_top verification failed");
    $finish;
  end

endmodule
